@@ rtl/vn_pkg.sv @@
// Shared widths for the vector normaliser pipeline.
// No dependencies; every rtl file uses it through scoped names.
package vn_pkg;

    localparam int COMP_BITS = 16;
    localparam int FRAC_BITS = 12;
    localparam int OUT_BITS  = FRAC_BITS + 2;
    localparam int SQ_BITS   = 2 * COMP_BITS;
    localparam int SUM_BITS  = 2 * COMP_BITS + 1;
    localparam int REM_BITS  = SUM_BITS + 1;
    localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
    localparam int QUO_BITS  = FRAC_BITS + 1;
    localparam int DIVD_BITS = COMP_BITS + FRAC_BITS;
    localparam int CMP_BITS  = ROOT_BITS + QUO_BITS;
    localparam int LANES     = 3;
    localparam int SIDE_BITS = LANES * (COMP_BITS + 1);
    // square, sum, one stage per root bit, one per quotient bit, output
    localparam int STAGES    = 3 + ROOT_BITS + QUO_BITS;
    localparam int SQRT_BASE = 2;
    localparam int DIV_BASE  = SQRT_BASE + ROOT_BITS;

    typedef struct packed {
        logic                 neg;
        logic [COMP_BITS-1:0] mag;
    } comp_side_t;

endpackage

@@ rtl/vector_normalize_q12_top.sv @@
// Top level of the vector normaliser: three square lanes, sum, pipelined root,
// three divider lanes and a sign-applying output register. Depends on vn_pkg and all rtl modules.
//
//  channel | handshake            | word
//  input   | in_valid / in_ready  | in_x, in_y, in_z   (signed 16 bit)
//  output  | out_valid / out_ready| unit_x, unit_y, unit_z (signed 14 bit, 12 fraction bits)
//
// One word accepted per cycle unless every stage is full and out_ready is low; the pipeline is square, sum,
// 17 root stages, 13 divider stages and the output register, one root bit and one quotient bit per stage.
// Each stage holds its word while the stage after it is occupied and stalled, so
// bubbles close up and input is taken whenever any stage ahead has room.
// rst_n clears only the stage valid bits.
module vector_normalize_q12_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vn_pkg::COMP_BITS-1:0] in_x,
    input  logic signed [vn_pkg::COMP_BITS-1:0] in_y,
    input  logic signed [vn_pkg::COMP_BITS-1:0] in_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vn_pkg::OUT_BITS-1:0]  unit_x,
    output logic signed [vn_pkg::OUT_BITS-1:0]  unit_y,
    output logic signed [vn_pkg::OUT_BITS-1:0]  unit_z
);

    logic [vn_pkg::STAGES-1:0] v_reg;
    logic [vn_pkg::STAGES-1:0] v_next;
    logic [vn_pkg::STAGES-1:0] load;

    logic signed [vn_pkg::COMP_BITS-1:0] comp   [vn_pkg::LANES];
    logic        [vn_pkg::COMP_BITS-1:0] mag    [vn_pkg::LANES];
    logic                                neg    [vn_pkg::LANES];
    logic        [vn_pkg::SQ_BITS-1:0]   sq     [vn_pkg::LANES];
    logic        [vn_pkg::QUO_BITS-1:0]  quo    [vn_pkg::LANES];
    logic                                qneg   [vn_pkg::LANES];
    logic signed [vn_pkg::OUT_BITS-1:0]  unit_reg [vn_pkg::LANES];

    logic [vn_pkg::SUM_BITS-1:0]  sum_reg;
    logic [vn_pkg::SIDE_BITS-1:0] side_reg;
    logic [vn_pkg::SIDE_BITS-1:0] side_next;
    logic [vn_pkg::SIDE_BITS-1:0] side_root;
    logic [vn_pkg::ROOT_BITS-1:0] root;

    // a stage loads when empty or when the stage after it loads
    always_comb
    begin
        load[vn_pkg::STAGES-1] = !v_reg[vn_pkg::STAGES-1] || out_ready;
        for (int k = vn_pkg::STAGES - 2; k >= 0; k--)
        begin
            load[k] = !v_reg[k] || load[k+1];
        end
        v_next = v_reg;
        for (int k = 0; k < vn_pkg::STAGES; k++)
        begin
            if (load[k])
            begin
                v_next[k] = (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign comp[0] = in_x;
    assign comp[1] = in_y;
    assign comp[2] = in_z;

    for (genvar l = 0; l < vn_pkg::LANES; l++)
    begin : g_sq
        vn_square_lane u_sq (
            .clk  (clk),
            .en   (load[0]),
            .comp (comp[l]),
            .mag  (mag[l]),
            .neg  (neg[l]),
            .sq   (sq[l])
        );
        assign side_next[l*(vn_pkg::COMP_BITS+1) +: vn_pkg::COMP_BITS+1] =
            vn_pkg::comp_side_t'({neg[l], mag[l]});
    end

    // merge the lane squares
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            sum_reg  <= vn_pkg::SUM_BITS'(sq[0]) + vn_pkg::SUM_BITS'(sq[1])
                      + vn_pkg::SUM_BITS'(sq[2]);
            side_reg <= side_next;
        end
    end

    vn_isqrt u_isqrt (
        .clk      (clk),
        .en       (load[vn_pkg::SQRT_BASE +: vn_pkg::ROOT_BITS]),
        .radicand (sum_reg),
        .side_in  (side_reg),
        .root     (root),
        .side_out (side_root)
    );

    for (genvar l = 0; l < vn_pkg::LANES; l++)
    begin : g_div
        vn_pkg::comp_side_t cs;
        assign cs = side_root[l*(vn_pkg::COMP_BITS+1) +: vn_pkg::COMP_BITS+1];

        vn_div_lane u_div (
            .clk     (clk),
            .en      (load[vn_pkg::DIV_BASE +: vn_pkg::QUO_BITS]),
            .mag     (cs.mag),
            .neg     (cs.neg),
            .dvs     (root),
            .quo     (quo[l]),
            .neg_out (qneg[l])
        );

        always_ff @(posedge clk)
        begin
            if (load[vn_pkg::STAGES-1])
            begin
                unit_reg[l] <= qneg[l] ? -vn_pkg::OUT_BITS'(quo[l])
                                       : vn_pkg::OUT_BITS'(quo[l]);
            end
        end
    end

    assign in_ready  = load[0];
    assign out_valid = v_reg[vn_pkg::STAGES-1];
    assign unit_x    = unit_reg[0];
    assign unit_y    = unit_reg[1];
    assign unit_z    = unit_reg[2];

`ifndef SYNTHESIS
    a_bound_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (unit_x >= -14'sd4096 && unit_x <= 14'sd4096))
        else $error("unit_x out of range");
    a_bound_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (unit_z >= -14'sd4096 && unit_z <= 14'sd4096))
        else $error("unit_z out of range");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> ($countones(v_reg) == vn_pkg::STAGES && !out_ready))
        else $error("input stalled with room in the pipeline");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready))
            |=> $countones(v_reg) == $countones($past(v_reg)) + 1)
        else $error("word lost or duplicated in pipeline");
`endif

endmodule

@@ rtl/vn_square_lane.sv @@
// One component lane: magnitude, sign and square, registered.
// Depends on vn_pkg.
module vn_square_lane (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vn_pkg::COMP_BITS-1:0] comp,
    output logic        [vn_pkg::COMP_BITS-1:0] mag,
    output logic                                neg,
    output logic        [vn_pkg::SQ_BITS-1:0]   sq
);

    logic [vn_pkg::COMP_BITS-1:0] mag_next;
    logic [vn_pkg::COMP_BITS-1:0] mag_reg;
    logic                         neg_reg;
    logic [vn_pkg::SQ_BITS-1:0]   sq_reg;

    // the most negative value keeps its full magnitude as unsigned
    assign mag_next = comp[vn_pkg::COMP_BITS-1] ? (~comp + 1'b1) : comp;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            neg_reg <= comp[vn_pkg::COMP_BITS-1];
            sq_reg  <= vn_pkg::SQ_BITS'(mag_next) * vn_pkg::SQ_BITS'(mag_next);
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
    assign sq  = sq_reg;

endmodule

@@ rtl/vn_isqrt.sv @@
// Pipelined floor square root, one root bit per stage, with sideband carried along.
// Depends on vn_pkg.
module vn_isqrt (
    input  logic                           clk,
    input  logic [vn_pkg::ROOT_BITS-1:0]   en,
    input  logic [vn_pkg::SUM_BITS-1:0]    radicand,
    input  logic [vn_pkg::SIDE_BITS-1:0]   side_in,
    output logic [vn_pkg::ROOT_BITS-1:0]   root,
    output logic [vn_pkg::SIDE_BITS-1:0]   side_out
);

    logic [vn_pkg::REM_BITS-1:0]  rem_reg  [vn_pkg::ROOT_BITS];
    logic [vn_pkg::ROOT_BITS-1:0] q_reg    [vn_pkg::ROOT_BITS];
    logic [vn_pkg::SIDE_BITS-1:0] side_reg [vn_pkg::ROOT_BITS];

    for (genvar s = 0; s < vn_pkg::ROOT_BITS; s++)
    begin : g_stage
        localparam int B = vn_pkg::ROOT_BITS - 1 - s;
        logic [vn_pkg::REM_BITS-1:0]  rem_in;
        logic [vn_pkg::ROOT_BITS-1:0] q_in;
        logic [vn_pkg::SIDE_BITS-1:0] sd_in;
        logic [vn_pkg::REM_BITS-1:0]  trial;
        logic                         take;

        if (s == 0)
        begin : g_first
            assign rem_in = vn_pkg::REM_BITS'(radicand);
            assign q_in   = '0;
            assign sd_in  = side_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign sd_in  = side_reg[s-1];
        end

        // (q + 2^B)^2 - q^2 = q*2^(B+1) + 4^B
        assign trial = (vn_pkg::REM_BITS'(q_in) << (B + 1))
                     + (vn_pkg::REM_BITS'(1) << (2 * B));
        assign take  = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= take ? rem_in - trial : rem_in;
                q_reg[s]    <= take ? (q_in | (vn_pkg::ROOT_BITS'(1) << B)) : q_in;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign root     = q_reg[vn_pkg::ROOT_BITS-1];
    assign side_out = side_reg[vn_pkg::ROOT_BITS-1];

endmodule

@@ rtl/vn_div_lane.sv @@
// Pipelined restoring divider lane: (mag << FRAC_BITS) / root, one quotient bit per stage.
// Depends on vn_pkg.
module vn_div_lane (
    input  logic                           clk,
    input  logic [vn_pkg::QUO_BITS-1:0]    en,
    input  logic [vn_pkg::COMP_BITS-1:0]   mag,
    input  logic                           neg,
    input  logic [vn_pkg::ROOT_BITS-1:0]   dvs,
    output logic [vn_pkg::QUO_BITS-1:0]    quo,
    output logic                           neg_out
);

    logic [vn_pkg::DIVD_BITS-1:0] rem_reg [vn_pkg::QUO_BITS];
    logic [vn_pkg::QUO_BITS-1:0]  q_reg   [vn_pkg::QUO_BITS];
    logic [vn_pkg::ROOT_BITS-1:0] dvs_reg [vn_pkg::QUO_BITS];
    logic                         neg_reg [vn_pkg::QUO_BITS];

    for (genvar s = 0; s < vn_pkg::QUO_BITS; s++)
    begin : g_stage
        localparam int B = vn_pkg::QUO_BITS - 1 - s;
        logic [vn_pkg::DIVD_BITS-1:0] rem_in;
        logic [vn_pkg::QUO_BITS-1:0]  q_in;
        logic [vn_pkg::ROOT_BITS-1:0] d_in;
        logic                         n_in;
        logic [vn_pkg::CMP_BITS-1:0]  shifted;
        logic [vn_pkg::CMP_BITS-1:0]  diff;
        logic                         take;

        if (s == 0)
        begin : g_first
            assign rem_in = vn_pkg::DIVD_BITS'(mag) << vn_pkg::FRAC_BITS;
            assign q_in   = '0;
            assign d_in   = dvs;
            assign n_in   = neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign d_in   = dvs_reg[s-1];
            assign n_in   = neg_reg[s-1];
        end

        assign shifted = vn_pkg::CMP_BITS'(d_in) << B;
        assign take    = vn_pkg::CMP_BITS'(rem_in) >= shifted;
        assign diff    = vn_pkg::CMP_BITS'(rem_in) - shifted;

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= take ? diff[vn_pkg::DIVD_BITS-1:0] : rem_in;
                q_reg[s]   <= take ? (q_in | (vn_pkg::QUO_BITS'(1) << B)) : q_in;
                dvs_reg[s] <= d_in;
                neg_reg[s] <= n_in;
            end
        end
    end

    // zero norm: every compare passes, so drop the quotient
    assign quo     = (dvs_reg[vn_pkg::QUO_BITS-1] == '0) ? '0 : q_reg[vn_pkg::QUO_BITS-1];
    assign neg_out = neg_reg[vn_pkg::QUO_BITS-1];

endmodule

@@ tb/sv/tb_vector_normalize_q12_top.sv @@
// Self-checking bench for vector_normalize_q12_top: random and corner 3D vectors
// are normalised by a local predictor and compared word by word. Depends on vn_pkg.
`timescale 1ns / 1ps

class unit_vec_board;
    typedef struct packed {
        logic signed [vn_pkg::OUT_BITS-1:0] x;
        logic signed [vn_pkg::OUT_BITS-1:0] y;
        logic signed [vn_pkg::OUT_BITS-1:0] z;
    } unit_t;

    unit_t pending_units[$];
    int    errors;

    function new();
        errors = 0;
    endfunction

    static function logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = v;
        root = 0;
        b    = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    static function logic [vn_pkg::OUT_BITS-1:0] scale(logic signed [15:0] c,
                                                      logic [63:0] norm);
        logic [63:0] m;
        logic [63:0] q;
        m = (c < 0) ? 64'(-$signed(65'(c))) : 64'(c);
        q = (norm > 0) ? ((m << vn_pkg::FRAC_BITS) / norm) : 64'd0;
        if (c < 0) q = -q;
        return q[vn_pkg::OUT_BITS-1:0];
    endfunction

    function void note_vector(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] zs;
        logic [63:0] sum;
        logic [63:0] norm;
        unit_t       u;
        // widen before squaring so the products keep every bit
        xs   = 64'(x);
        ys   = 64'(y);
        zs   = 64'(z);
        sum  = xs * xs + ys * ys + zs * zs;
        norm = isqrt(sum);
        u.x  = scale(x, norm);
        u.y  = scale(y, norm);
        u.z  = scale(z, norm);
        pending_units.push_back(u);
    endfunction

    function void check_unit(unit_t got);
        unit_t exp_u;
        if (pending_units.size() == 0)
        begin
            $error("unexpected word x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            errors++;
            return;
        end
        exp_u = pending_units.pop_front();
        if (got.x !== exp_u.x)
        begin
            $error("unit_x expected %0d actual %0d", exp_u.x, got.x);
            errors++;
        end
        if (got.y !== exp_u.y)
        begin
            $error("unit_y expected %0d actual %0d", exp_u.y, got.y);
            errors++;
        end
        if (got.z !== exp_u.z)
        begin
            $error("unit_z expected %0d actual %0d", exp_u.z, got.z);
            errors++;
        end
    endfunction
endclass

module tb_vector_normalize_q12_top;
    localparam int LATENCY   = vn_pkg::STAGES;
    localparam int MAX_CYCLE = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] in_x, in_y, in_z;
    logic out_valid;
    logic out_ready;
    logic signed [vn_pkg::OUT_BITS-1:0] unit_x, unit_y, unit_z;

    unit_vec_board board;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycle_count = 0;

    vector_normalize_q12_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // check results and hold the watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_unit('{unit_x, unit_y, unit_z});
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls at random
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_x     <= x;
        in_y     <= y;
        in_z     <= z;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_vector(x, y, z);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(32)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_x           = '0;
        in_y           = '0;
        in_z           = '0;
        out_ready      = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners: zero, most negative, extremes, axes, tiny
        send_vector(0, 0, 0);
        send_vector(-32768, -32768, -32768);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, 0, 0);
        send_vector(0, 32767, 0);
        send_vector(0, 0, -1);
        send_vector(1, 1, 1);
        send_vector(-1, -1, -1);
        send_vector(32767, -32768, 0);
        send_vector(3, 4, 0);
        send_vector(-3, 0, 4);
        send_vector(1, 0, 0);
        send_vector(16'sh5555, 16'shaaaa, 16'sh0f0f);
        send_vector(-16'sh5555, 16'sh2aaa, -16'sh7070);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            repeat (125) send_vector(rand_comp(), rand_comp(), rand_comp());
        end
        in_valid <= 1'b0;

        recv_stall_pct = 0;
        while (board.pending_units.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
